// ===== rtl/tst_pkg.sv =====
// ============================================================================
// tst_pkg
// Shared types and constants for the topic subscription table: operation and
// status codes, controller states and the command/status bundles between the
// controller and the datapath.
// ============================================================================
package tst_pkg;

	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int TOPIC_W  = 32;
	localparam int STATUS_W = 3;

	typedef enum logic {
		OP_SUBSCRIBE = 1'b0,
		OP_PUBLISH   = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED   = 3'd0,
		ST_ALREADY = 3'd1,
		ST_FULL    = 3'd2,
		ST_DEST    = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the input item and restart the scan
		logic step;   // consume the entry in the read stage
		logic rd_en;  // issue a table read at the scan index
		logic fin;    // produce the closing result of the item
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic all_issued;  // every filled entry has been read
		logic s1_vld;      // read stage holds an entry
		logic s1_block;    // entry in the read stage cannot move this cycle
		logic out_free;    // output register can take a result
	} sts_t;

endpackage

// ===== rtl/tst_ctrl.sv =====
// ============================================================================
// tst_ctrl
// Controller for the topic subscription table: takes one item at a time,
// walks the filled part of the table and then closes the item.
// ============================================================================
module tst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tst_pkg::sts_t sts,
	output tst_pkg::cmd_t cmd
);
	import tst_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				// advance one entry a cycle unless a destination waits for the output
				cmd.step  = !sts.s1_block;
				cmd.rd_en = !sts.s1_block && !sts.all_issued;
				if (sts.all_issued && !sts.s1_vld) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.fin = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tst_dp.sv =====
// ============================================================================
// tst_dp
// Datapath for the topic subscription table: item registers, the entry
// memory with its fill count, the compare stage, a hold register that keeps
// the latest destination until the next one shows whether it was the last,
// and the output register.
// ============================================================================
module tst_dp #(
	parameter int TABLE_ENTRIES = 64,
	parameter int KEY_W         = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tst_pkg::cmd_t                    cmd,
	output tst_pkg::sts_t                    sts,
	input  tst_pkg::op_t                     in_op,
	input  logic [tst_pkg::TOPIC_W-1:0]      in_key,
	input  logic [tst_pkg::IP_W-1:0]         in_ip,
	input  logic [tst_pkg::PORT_W-1:0]       in_port,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tst_pkg::status_t                 out_status,
	output logic [tst_pkg::IP_W-1:0]         out_ip,
	output logic [tst_pkg::PORT_W-1:0]       out_port,
	output logic                             out_last
);
	import tst_pkg::*;

	localparam int CW     = $clog2(TABLE_ENTRIES + 1);
	localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ENTRY_W = KEY_W + IP_W + PORT_W;

	// item registers
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [IP_W-1:0]   ip_q;
	logic [PORT_W-1:0] port_q;

	// table: entries below the fill count are valid
	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;

	// read stage
	logic               s1_vld_q;
	logic [ENTRY_W-1:0] rdata_s1;

	logic              found_q;
	logic              hold_vld_q;
	logic [IP_W-1:0]   hold_ip_q;
	logic [PORT_W-1:0] hold_port_q;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [IP_W-1:0]   out_ip_q;
	logic [PORT_W-1:0] out_port_q;
	logic              out_last_q;

	logic              pub;
	logic              topic_hit;
	logic              addr_hit;
	logic              full;
	logic              out_free;
	logic              take_hit;
	logic              push_hold;
	logic              wr_en;
	logic [IP_W-1:0]   s1_ip;
	logic [PORT_W-1:0] s1_port;

	assign pub       = (op_q == OP_PUBLISH);
	assign s1_ip     = rdata_s1[KEY_W +: IP_W];
	assign s1_port   = rdata_s1[KEY_W + IP_W +: PORT_W];
	assign topic_hit = (rdata_s1[KEY_W-1:0] == key_q);
	assign addr_hit  = (s1_ip == ip_q) && (s1_port == port_q);
	assign full      = (cnt_q == CW'(TABLE_ENTRIES));
	assign out_free  = !out_vld_q || out_ready;
	assign take_hit  = cmd.step && s1_vld_q && topic_hit;
	assign push_hold = take_hit && pub && hold_vld_q;
	assign wr_en     = cmd.fin && !pub && !found_q && !full;

	assign sts.all_issued = (idx_q == cnt_q);
	assign sts.s1_vld     = s1_vld_q;
	assign sts.s1_block   = s1_vld_q && pub && topic_hit && hold_vld_q && !out_free;
	assign sts.out_free   = out_free;

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			key_q  <= in_key[KEY_W-1:0];
			ip_q   <= in_ip;
			port_q <= in_port;
		end
	end

	// entry memory: append at the fill count, read at the scan index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IW-1:0]] <= {port_q, ip_q, key_q};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[idx_q[IW-1:0]];
		end
	end

	// scan control, fill count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			s1_vld_q   <= 1'b0;
			found_q    <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q      <= '0;
				s1_vld_q   <= 1'b0;
				found_q    <= 1'b0;
				hold_vld_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					idx_q <= idx_q + CW'(1);
				end
				if (cmd.step) begin
					s1_vld_q <= cmd.rd_en;
				end
				if (take_hit && !pub && addr_hit) begin
					found_q <= 1'b1;
				end
				if (take_hit && pub) begin
					hold_vld_q <= 1'b1;
				end else if (cmd.fin) begin
					hold_vld_q <= 1'b0;
				end
			end
			if (wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// hold the newest destination
	always_ff @(posedge clk) begin
		if (take_hit && pub) begin
			hold_ip_q   <= s1_ip;
			hold_port_q <= s1_port;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push_hold || cmd.fin) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output payload: an earlier destination, or the closing result
	always_ff @(posedge clk) begin
		if (push_hold) begin
			out_status_q <= ST_DEST;
			out_ip_q     <= hold_ip_q;
			out_port_q   <= hold_port_q;
			out_last_q   <= 1'b0;
		end else if (cmd.fin) begin
			out_last_q <= 1'b1;
			out_ip_q   <= '0;
			out_port_q <= '0;
			if (pub) begin
				if (hold_vld_q) begin
					out_status_q <= ST_DEST;
					out_ip_q     <= hold_ip_q;
					out_port_q   <= hold_port_q;
				end else begin
					out_status_q <= ST_NONE;
				end
			end else if (found_q) begin
				out_status_q <= ST_ALREADY;
			end else if (full) begin
				out_status_q <= ST_FULL;
			end else begin
				out_status_q <= ST_ADDED;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_status = out_status_q;
	assign out_ip     = out_ip_q;
	assign out_port   = out_port_q;
	assign out_last   = out_last_q;

endmodule

// ===== rtl/topic_subscription_table.sv =====
// ============================================================================
// topic_subscription_table
// Publish/subscribe table of (topic, client address) subscriptions.
// ============================================================================
// Use: items enter on the s_ channel. s_tuser selects subscribe (0) or
// publish (1); s_tdata carries topic key, client IP and client port.
// A subscribe gives one result (added, already subscribed, table full).
// A publish gives one destination per matching entry in table order, the
// final one with m_tlast set, or a single no-subscriber result.
// Results leave on the m_ channel, status in m_tuser, address in m_tdata.
// Steps per item: capture, one read per filled entry (at most TABLE_ENTRIES)
// from the single read port of the entry memory, draining the read stage, and
// the closing cycle; only after it can the next item transfer.
// The closing result shows on m_tvalid the cycle after the closing cycle.
// A stalled m_tready freezes the scan when a further match must pass a result
// still waiting in the output register, and holds the closing cycle until
// that register drains; the next item can be taken while a result waits.
// Reset clears the fill count, so the table starts empty, with no sweep.
// ============================================================================
module topic_subscription_table #(
	parameter int TABLE_ENTRIES  = 64,
	parameter int TOPIC_KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // topic_key[31:0], client_ip[63:32], client_port[79:64]
	input  logic [0:0]  s_tuser,   // operation[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // dest_ip[31:0], dest_port[47:32]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast
);
	import tst_pkg::*;

	localparam int KEY_W = (TOPIC_KEY_BITS < TOPIC_W) ? TOPIC_KEY_BITS : TOPIC_W;

	cmd_t              cmd;
	sts_t              sts;
	status_t           out_status;
	logic [IP_W-1:0]   out_ip;
	logic [PORT_W-1:0] out_port;

	tst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tst_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_W         (KEY_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (op_t'(s_tuser[0])),
		.in_key     (s_tdata[31:0]),
		.in_ip      (s_tdata[63:32]),
		.in_port    (s_tdata[79:64]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_ip     (out_ip),
		.out_port   (out_port),
		.out_last   (m_tlast)
	);

	assign m_tuser = out_status;
	assign m_tdata = {out_port, out_ip};

`ifndef NO_ASSERTIONS
	// closing result only when the output register can take it
	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("closing result issued while output register busy");

	// a new item starts with an empty read stage
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !sts.s1_vld)
		else $error("read stage not cleared after item capture");

	// every table read lands in the read stage
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> sts.s1_vld)
		else $error("table read did not reach the read stage");
`endif

endmodule

// ===== verif/topic_subscription_table_tb.sv =====
// ============================================================================
// topic_subscription_table_tb
// Self-checking bench for the subscription table. A local copy of the table
// predicts the replies of every accepted item; a sink process compares each
// reply transfer field by field against the oldest prediction. Directed tests
// cover empty-table publishes, address and topic extremes, duplicates and
// fan-out. Random tests mix pooled subscriptions and publishes, fill the
// table to its limit, hold the receiver off for a long stretch, and finish
// with a run at full rate on both sides.
// ============================================================================
module topic_subscription_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tst_pkg::*;

	localparam int ENTRIES     = 64;
	localparam int KEY_BITS    = 32;
	localparam int LIMIT       = 3000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINT   = 40;
	localparam int TOPIC_POOL  = 6;
	localparam int CLIENT_POOL = 12;
	localparam logic [TOPIC_W-1:0] KEY_MASK = TOPIC_W'((64'd1 << KEY_BITS) - 64'd1);

	typedef struct {
		status_t           status;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic              last;
	} reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;   // topic_key[31:0], client_ip[63:32], client_port[79:64]
	logic [0:0]  s_tuser  = '0;   // operation[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // dest_ip[31:0], dest_port[47:32]
	logic [2:0]  m_tuser;         // status[2:0]
	logic        m_tlast;

	// shadow copy of the subscription table
	bit                sub_valid [ENTRIES];
	logic [TOPIC_W-1:0] sub_topic [ENTRIES];
	logic [IP_W-1:0]   sub_ip    [ENTRIES];
	logic [PORT_W-1:0] sub_port  [ENTRIES];
	int                table_fill;

	reply_t pending_replies [$];

	// random pools so that duplicates and fan-out happen often
	logic [TOPIC_W-1:0] topic_pool [TOPIC_POOL];
	logic [IP_W-1:0]    pool_ip    [CLIENT_POOL];
	logic [PORT_W-1:0]  pool_port  [CLIENT_POOL];

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int err_count = 0;

	topic_subscription_table #(
		.TABLE_ENTRIES  (ENTRIES),
		.TOPIC_KEY_BITS (KEY_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINT) begin
			$display("tb: mismatch at %0t: %s", $time, msg);
		end
		err_count++;
	endtask

	// Update the shadow table and queue the replies one item causes
	function automatic void predict_replies(input op_t op, input logic [TOPIC_W-1:0] raw_key,
			input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
		logic [TOPIC_W-1:0] key;
		int free_idx;
		bit dup;
		bit have_prev;
		reply_t r;
		reply_t prev;
		key = raw_key & KEY_MASK;
		free_idx = -1;
		dup = 1'b0;
		have_prev = 1'b0;
		if (op == OP_SUBSCRIBE) begin
			r = '{ST_ADDED, '0, '0, 1'b1};
			for (int i = 0; i < ENTRIES; i++) begin
				if (sub_valid[i]) begin
					if (sub_topic[i] == key && sub_ip[i] == ip && sub_port[i] == port)
						dup = 1'b1;
				end else if (free_idx < 0) begin
					free_idx = i;
				end
			end
			if (dup) begin
				r.status = ST_ALREADY;
			end else if (free_idx < 0) begin
				r.status = ST_FULL;
			end else begin
				sub_valid[free_idx] = 1'b1;
				sub_topic[free_idx] = key;
				sub_ip[free_idx]    = ip;
				sub_port[free_idx]  = port;
				table_fill++;
			end
			pending_replies.push_back(r);
		end else begin
			// one destination per match in index order, mark the final one
			for (int i = 0; i < ENTRIES; i++) begin
				if (sub_valid[i] && sub_topic[i] == key) begin
					if (have_prev) pending_replies.push_back(prev);
					prev = '{ST_DEST, sub_ip[i], sub_port[i], 1'b0};
					have_prev = 1'b1;
				end
			end
			if (have_prev) begin
				prev.last = 1'b1;
				pending_replies.push_back(prev);
			end else begin
				pending_replies.push_back('{ST_NONE, '0, '0, 1'b1});
			end
		end
	endfunction

	// Offer one item, wait for its transfer, then predict its replies
	task automatic send_item(input op_t op, input logic [TOPIC_W-1:0] key,
			input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {port, ip, key};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_replies(op, key, ip, port);
	endtask

	// Stop offering and hold until every predicted reply has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Pick a pooled subscribe, a pooled publish, or some noise
	task automatic send_random_item();
		int roll;
		int c;
		roll = $urandom_range(0, 99);
		c = $urandom_range(0, CLIENT_POOL - 1);
		if (roll < 45) begin
			send_item(OP_SUBSCRIBE, topic_pool[$urandom_range(0, TOPIC_POOL - 1)],
				pool_ip[c], pool_port[c]);
		end else if (roll < 80) begin
			send_item(OP_PUBLISH, topic_pool[$urandom_range(0, TOPIC_POOL - 1)],
				$urandom, PORT_W'($urandom));
		end else if (roll < 90) begin
			send_item(OP_PUBLISH, $urandom, $urandom, PORT_W'($urandom));
		end else begin
			send_item(OP_SUBSCRIBE, $urandom, $urandom, PORT_W'($urandom));
		end
	endtask

	task automatic test_empty_table();
		send_item(OP_PUBLISH, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_PUBLISH, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
		wait_drained();
	endtask

	task automatic test_subscribe_cases();
		send_item(OP_SUBSCRIBE, 32'h0000_0000, 32'h0000_0000, 16'h0000);
		send_item(OP_SUBSCRIBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_SUBSCRIBE, 32'h0000_0000, 32'h0000_0000, 16'h0000);
		send_item(OP_SUBSCRIBE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
		send_item(OP_SUBSCRIBE, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
		send_item(OP_SUBSCRIBE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
		send_item(OP_SUBSCRIBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		// address fields of a publish are ignored
		send_item(OP_PUBLISH, 32'h0000_0000, $urandom, PORT_W'($urandom));
		send_item(OP_PUBLISH, 32'hFFFF_FFFF, $urandom, PORT_W'($urandom));
		send_item(OP_PUBLISH, 32'h5A5A_5A5A, 32'h0000_0000, 16'h0000);
		wait_drained();
	endtask

	task automatic test_fanout();
		logic [TOPIC_W-1:0] topic;
		topic = $urandom;
		repeat (5) send_item(OP_SUBSCRIBE, topic, $urandom, PORT_W'($urandom));
		send_item(OP_PUBLISH, topic, 32'h0000_0000, 16'h0000);
		send_item(OP_PUBLISH, topic, 32'hFFFF_FFFF, 16'hFFFF);
		wait_drained();
	endtask

	// Receiver stalls for a long stretch while items keep coming
	task automatic test_receiver_hold();
		hold_req = 1'b1;
		for (int k = 0; k < 24; k++) begin
			if (k % 3 == 0) begin
				send_item(OP_PUBLISH, (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, $urandom,
					PORT_W'($urandom));
			end else begin
				case ($urandom_range(0, 2))
					0: send_item(OP_SUBSCRIBE, 32'h0000_0000, $urandom, PORT_W'($urandom));
					1: send_item(OP_SUBSCRIBE, 32'hFFFF_FFFF, $urandom, PORT_W'($urandom));
					default: send_item(OP_SUBSCRIBE, $urandom, $urandom, PORT_W'($urandom));
				endcase
			end
		end
		wait_drained();
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < TOPIC_POOL; i++) topic_pool[i] = $urandom;
		for (int i = 0; i < CLIENT_POOL; i++) begin
			pool_ip[i]   = $urandom;
			pool_port[i] = PORT_W'($urandom);
		end
		repeat (130) send_random_item();
		wait_drained();
	endtask

	// Fill every free entry, then hit the full table
	task automatic test_table_full();
		while (table_fill < ENTRIES)
			send_item(OP_SUBSCRIBE, topic_pool[0], $urandom, PORT_W'($urandom));
		repeat (3) send_item(OP_SUBSCRIBE, $urandom, $urandom, PORT_W'($urandom));
		send_item(OP_SUBSCRIBE, 32'h0000_0000, 32'h0000_0000, 16'h0000);
		send_item(OP_PUBLISH, topic_pool[0], $urandom, PORT_W'($urandom));
		wait_drained();
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		repeat (30) send_random_item();
		wait_drained();
	endtask

	// Compare each reply transfer with the oldest prediction; pace m_tready
	initial begin : reply_sink
		int stall_left;
		reply_t want;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected reply status %0d ip %h port %h",
						m_tuser, m_tdata[31:0], m_tdata[47:32]));
				end else begin
					want = pending_replies.pop_front();
					if (m_tuser !== want.status)
						report_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
					if (m_tdata[31:0] !== want.ip)
						report_mismatch($sformatf("dest_ip got %h want %h", m_tdata[31:0], want.ip));
					if (m_tdata[47:32] !== want.port)
						report_mismatch($sformatf("dest_port got %h want %h",
							m_tdata[47:32], want.port));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// End the run when nothing transfers for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_subscribe_cases();
		test_fanout();
		test_receiver_hold();
		test_random_mix();
		test_table_full();
		test_full_rate();
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tst_pkg.sv
rtl/tst_ctrl.sv
rtl/tst_dp.sv
rtl/topic_subscription_table.sv
verif/topic_subscription_table_tb.sv
